/* src/text_cell_pixel_renderer_core_assert.svh */
// assertion macros for the text cell pixel renderer
// included by the rtl files that check their own control logic
`ifndef TEXT_CELL_PIXEL_RENDERER_CORE_ASSERT_SVH
`define TEXT_CELL_PIXEL_RENDERER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define TCPR_ASSERT_IMP(lbl, ck, rn, a, c, m) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(m);
// antecedent implies consequent in the next cycle
`define TCPR_ASSERT_NXT(lbl, ck, rn, a, c, m) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(m);
`else
`define TCPR_ASSERT_IMP(lbl, ck, rn, a, c, m)
`define TCPR_ASSERT_NXT(lbl, ck, rn, a, c, m)
`endif

`endif

/* src/tcpr_pkg.sv */
// shared types, constants and colour helpers of the text cell pixel renderer
// no dependencies
package tcpr_pkg;

  // default geometry
  localparam int TEXT_COLUMNS_DEF = 80;
  localparam int TEXT_ROWS_DEF    = 25;
  localparam int GLYPH_HEIGHT_DEF = 11;
  localparam int RGB_WIDTH_DEF    = 480;
  localparam int RGB_HEIGHT_DEF   = 300;

  // field widths
  localparam int POS_W     = 18;
  localparam int COORD_W   = 9;
  localparam int PIX_W     = 24;
  localparam int PCNT_W    = 3;
  localparam int COLOR_W   = 6;
  localparam int PAL_DEPTH = 16;
  localparam int PAL_IDX_W = 4;
  localparam int GBITS_W   = 6;
  localparam int CODE_W    = 8;
  localparam int CHAR_COUNT = 256;
  localparam int CELL_WIDTH = 6;

  localparam logic [PCNT_W-1:0] PIXEL_COUNT_TEXT = 3'd6;
  localparam logic [PCNT_W-1:0] PIXEL_COUNT_RGB  = 3'd1;

  // reciprocal divider, divisors up to 1024
  localparam int DIV_SHIFT = 28;
  localparam int RECIP_W   = 29;
  localparam int DIVISOR_W = 11;
  localparam int REM_W     = 10;

  typedef enum logic [1:0] {
    ACT_TEXT    = 2'd0,
    ACT_RGB     = 2'd1,
    ACT_PALETTE = 2'd2,
    ACT_GLYPH   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_TEXT,
    ST_RGB
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [PAL_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   data;
  } pal_wr_t;

  typedef struct packed {
    logic                 en;
    logic [PAL_IDX_W-1:0] fg_idx;
    logic [PAL_IDX_W-1:0] bg_idx;
  } pal_rd_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_res_t;

  localparam logic [COLOR_W-1:0] PALETTE_INIT [PAL_DEPTH] = '{
    6'h00, 6'h30, 6'h0C, 6'h03, 6'h3C, 6'h33, 6'h0F, 6'h10,
    6'h04, 6'h01, 6'h14, 6'h11, 6'h05, 6'h3f, 6'h2a, 6'h15
  };

  // 2-2-2 palette colour to 8-8-8, each channel times 85
  function automatic logic [PIX_W-1:0] expand_color(input logic [COLOR_W-1:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {6'd0, c[5:4]} * 8'd85;
    g = {6'd0, c[3:2]} * 8'd85;
    b = {6'd0, c[1:0]} * 8'd85;
    return {r, g, b};
  endfunction

  // 3-3-2 pixel byte to 8-8-8
  function automatic logic [PIX_W-1:0] expand_rgb332(input logic [CODE_W-1:0] p);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {5'd0, p[7:5]} * 8'd36;
    g = {5'd0, p[4:2]} * 8'd36;
    b = {6'd0, p[1:0]} * 8'd85;
    return {r, g, b};
  endfunction

endpackage

/* src/tcpr_palette.sv */
// 16-entry palette memory with two registered read ports
// depends on tcpr_pkg; unwritten entries read as the reset colour table
module tcpr_palette import tcpr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pal_wr_t            wr,
  input  pal_rd_t            rd,
  output logic [COLOR_W-1:0] fg_color,
  output logic [COLOR_W-1:0] bg_color
);

  logic [COLOR_W-1:0]   pal_mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] written_r;
  logic [COLOR_W-1:0]   fg_r;
  logic [COLOR_W-1:0]   bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr.en) begin
      written_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      pal_mem[wr.idx] <= wr.data;
    end
    if (rd.en) begin
      fg_r <= written_r[rd.fg_idx] ? pal_mem[rd.fg_idx] : PALETTE_INIT[rd.fg_idx];
      bg_r <= written_r[rd.bg_idx] ? pal_mem[rd.bg_idx] : PALETTE_INIT[rd.bg_idx];
    end
  end

  assign fg_color = fg_r;
  assign bg_color = bg_r;

endmodule

/* src/tcpr_glyph_mem.sv */
// glyph row store, one write and one registered read port
// depends on tcpr_pkg
module tcpr_glyph_mem import tcpr_pkg::*; #(
  parameter int DEPTH  = CHAR_COUNT * GLYPH_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [GBITS_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [GBITS_W-1:0] rdata
);

  logic [GBITS_W-1:0] glyph_mem [DEPTH];
  logic [GBITS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      glyph_mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= glyph_mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tcpr_divc.sv */
// two-stage divider by one of two constants, reciprocal multiply and one correction
// depends on tcpr_pkg and the assertion macro header
module tcpr_divc import tcpr_pkg::*; #(
  parameter int D0 = TEXT_COLUMNS_DEF,
  parameter int D1 = RGB_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             sel,
  input  logic [POS_W-1:0] pos,
  output div_res_t         res
);

  `include "text_cell_pixel_renderer_core_assert.svh"

  localparam int PROD_W = POS_W + RECIP_W;
  localparam logic [RECIP_W-1:0]   M0  = RECIP_W'((64'd1 << DIV_SHIFT) / D0);
  localparam logic [RECIP_W-1:0]   M1  = RECIP_W'((64'd1 << DIV_SHIFT) / D1);
  localparam logic [DIVISOR_W-1:0] DV0 = DIVISOR_W'(D0);
  localparam logic [DIVISOR_W-1:0] DV1 = DIVISOR_W'(D1);

  logic               busy_r;
  logic               done_r;
  logic [PROD_W-1:0]  prod_r;
  logic [POS_W-1:0]   pos_r;
  logic               sel_r;
  logic [POS_W-1:0]   quot_r;
  logic [REM_W-1:0]   rem_r;

  logic [RECIP_W-1:0]   m_sel;
  logic [PROD_W-1:0]    prod_nxt;
  logic [POS_W-1:0]     q_est;
  logic [DIVISOR_W-1:0] d_sel;
  logic [POS_W:0]       qd;
  logic [POS_W:0]       rem_wide;
  logic                 fix;
  logic [POS_W-1:0]     quot_nxt;
  logic [REM_W-1:0]     rem_nxt;

  // stage 1: estimate never exceeds the true quotient, falls short by at most one
  always_comb begin
    m_sel    = sel ? M1 : M0;
    prod_nxt = PROD_W'(pos) * PROD_W'(m_sel);
  end

  // stage 2: remainder and correction
  always_comb begin
    q_est    = prod_r[DIV_SHIFT +: POS_W];
    d_sel    = sel_r ? DV1 : DV0;
    qd       = {1'b0, q_est} * (POS_W+1)'(d_sel);
    rem_wide = {1'b0, pos_r} - qd;
    fix      = rem_wide >= (POS_W+1)'(d_sel);
    quot_nxt = fix ? q_est + 1'b1 : q_est;
    rem_nxt  = fix ? REM_W'(rem_wide - (POS_W+1)'(d_sel)) : REM_W'(rem_wide);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_nxt;
      pos_r  <= pos;
      sel_r  <= sel;
    end
    if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign res = '{done: done_r, quot: quot_r, rem: rem_r};

  `TCPR_ASSERT_IMP(a_rem_range, clk, rst_n, done_r, DIVISOR_W'(rem_r) < d_sel, "remainder out of range")

endmodule

/* src/text_cell_pixel_renderer_core.sv */
// top level of the text cell pixel renderer
// depends on tcpr_pkg, tcpr_palette, tcpr_glyph_mem, tcpr_divc and the assertion macro header

// Text cell pixel renderer. Four kinds of transaction come in on the in_ channel:
// a palette write and a glyph row write update the palette or glyph store in the
// cycle they are accepted and give no result; an rgb pixel gives one result with
// one pixel; a text cell gives GLYPH_HEIGHT+1 results of six pixels, one per screen
// line, the last being the background spacing line, with out_last on the final one.
// A text cell holds the input from its accept cycle to the next accept cycle: it is
// accepted, the constant divider splits the cell index into column and row, the first
// glyph row is read from the store's single read port, then one result line per cycle
// follows while out_ready does not stall, GLYPH_HEIGHT+1 lines, with the next row read
// alongside each. An rgb pixel likewise holds the input through the divider until its
// result is loaded into the output register. A position past the text or rgb screen
// area is accepted and dropped. The glyph store has no reset; a glyph row must be
// written before a text cell uses it. Palette entries read as the default sixteen
// colour table until written.
module text_cell_pixel_renderer_core import tcpr_pkg::*; #(
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int RGB_WIDTH    = RGB_WIDTH_DEF,
  parameter int RGB_HEIGHT   = RGB_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [POS_W-1:0]     in_position,
  input  logic [7:0]           in_attribute,
  input  logic [CODE_W-1:0]    in_code,
  input  logic [PAL_IDX_W-1:0] in_palette_index,
  input  logic [7:0]           in_palette_value,
  input  logic [3:0]           in_glyph_row,
  input  logic [GBITS_W-1:0]   in_glyph_bits,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COORD_W-1:0]   out_screen_x,
  output logic [COORD_W-1:0]   out_screen_y,
  output logic [PIX_W-1:0]     out_pixel_0,
  output logic [PIX_W-1:0]     out_pixel_1,
  output logic [PIX_W-1:0]     out_pixel_2,
  output logic [PIX_W-1:0]     out_pixel_3,
  output logic [PIX_W-1:0]     out_pixel_4,
  output logic [PIX_W-1:0]     out_pixel_5,
  output logic [PCNT_W-1:0]    out_pixel_count,
  output logic                 out_last
);

  `include "text_cell_pixel_renderer_core_assert.svh"

  localparam int TEXT_LIMIT  = TEXT_COLUMNS * TEXT_ROWS;
  localparam int RGB_LIMIT   = RGB_WIDTH * RGB_HEIGHT;
  localparam int GLYPH_DEPTH = CHAR_COUNT * GLYPH_HEIGHT;
  localparam int GADDR_W     = $clog2(GLYPH_DEPTH);
  localparam int ROW_CNT_W   = $clog2(GLYPH_HEIGHT + 1);
  localparam logic [ROW_CNT_W-1:0] LAST_ROW = ROW_CNT_W'(GLYPH_HEIGHT);

  state_t state_r, state_nxt;

  // transaction being worked on
  logic                  is_text_r;
  logic [CODE_W-1:0]     code_r;
  logic [COORD_W-1:0]    sx_r;
  logic [COORD_W-1:0]    sy_r;

  // glyph row pipeline: rd_cnt counts reads issued, emit_cnt lines sent,
  // rdv marks read data waiting in the store's output register
  logic [ROW_CNT_W-1:0]  rd_cnt_r;
  logic [ROW_CNT_W-1:0]  emit_cnt_r;
  logic                  rdv_r;

  // output register
  logic                  out_valid_r;
  logic [COORD_W-1:0]    out_x_r,   out_x_nxt;
  logic [COORD_W-1:0]    out_y_r,   out_y_nxt;
  logic [PIX_W-1:0]      pix_r   [6];
  logic [PIX_W-1:0]      pix_nxt [6];
  logic [PCNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  in_accept;
  action_t               in_act;
  logic                  text_ok;
  logic                  rgb_ok;
  logic                  div_start;
  logic                  glyph_we;
  logic [GADDR_W-1:0]    glyph_waddr;
  logic                  glyph_re;
  logic [GADDR_W-1:0]    glyph_raddr;
  logic [GBITS_W-1:0]    glyph_rdata;
  pal_wr_t               pal_wr;
  pal_rd_t               pal_rd;
  logic [COLOR_W-1:0]    fg_color;
  logic [COLOR_W-1:0]    bg_color;
  logic [PIX_W-1:0]      fg_rgb;
  logic [PIX_W-1:0]      bg_rgb;
  div_res_t              div_res;
  logic                  out_free;
  logic                  need_data;
  logic                  can_emit;
  logic                  load_out;

  // ---------------------------------------------------------------------------
  // input side: writes land in the accept cycle, renders start the divider
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign in_act    = action_t'(in_action);
  assign text_ok   = 32'(in_position) < TEXT_LIMIT;
  assign rgb_ok    = 32'(in_position) < RGB_LIMIT;

  // out-of-area positions never leave idle
  assign div_start = in_accept && (((in_act == ACT_TEXT) && text_ok) ||
                                   ((in_act == ACT_RGB) && rgb_ok));

  // palette write drops the top two colour bits
  assign pal_wr = '{en:   in_accept && (in_act == ACT_PALETTE),
                    idx:  in_palette_index,
                    data: in_palette_value[COLOR_W-1:0]};

  // both colours are looked up once per text cell, at acceptance
  assign pal_rd = '{en:     in_accept && (in_act == ACT_TEXT),
                    fg_idx: in_attribute[3:0],
                    bg_idx: in_attribute[7:4]};

  // glyph row writes past the glyph height are ignored
  assign glyph_we    = in_accept && (in_act == ACT_GLYPH) && (32'(in_glyph_row) < GLYPH_HEIGHT);
  assign glyph_waddr = GADDR_W'(32'(in_code) * GLYPH_HEIGHT + 32'(in_glyph_row));

  always_ff @(posedge clk) begin
    if (div_start) begin
      is_text_r <= (in_act == ACT_TEXT);
      code_r    <= in_code;
    end
    // cell origin on screen, cut to the coordinate width
    if ((state_r == ST_DIV) && div_res.done) begin
      sx_r <= COORD_W'(32'(div_res.rem) * CELL_WIDTH);
      sy_r <= COORD_W'(32'(div_res.quot) * (GLYPH_HEIGHT + 1));
    end
  end

  // ---------------------------------------------------------------------------
  // submodules
  // ---------------------------------------------------------------------------
  tcpr_palette u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (pal_wr),
    .rd       (pal_rd),
    .fg_color (fg_color),
    .bg_color (bg_color)
  );

  tcpr_glyph_mem #(
    .DEPTH  (GLYPH_DEPTH),
    .ADDR_W (GADDR_W)
  ) u_glyph_mem (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (glyph_waddr),
    .wdata (in_glyph_bits),
    .re    (glyph_re),
    .raddr (glyph_raddr),
    .rdata (glyph_rdata)
  );

  // text cells divide by the column count, rgb pixels by the screen width
  tcpr_divc #(
    .D0 (TEXT_COLUMNS),
    .D1 (RGB_WIDTH)
  ) u_divc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sel   (in_act == ACT_RGB),
    .pos   (in_position),
    .res   (div_res)
  );

  assign fg_rgb = expand_color(fg_color);
  assign bg_rgb = expand_color(bg_color);

  // ---------------------------------------------------------------------------
  // glyph row read pipeline; the store is only written while idle, so reads
  // here never meet a write to the same row
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_r || out_ready;
  assign need_data   = emit_cnt_r < LAST_ROW;
  assign can_emit    = (state_r == ST_TEXT) && out_free && (!need_data || rdv_r);
  assign glyph_re    = (state_r == ST_TEXT) && (rd_cnt_r < LAST_ROW) && (!rdv_r || can_emit);
  assign glyph_raddr = GADDR_W'(32'(code_r) * GLYPH_HEIGHT + 32'(rd_cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r   <= '0;
      emit_cnt_r <= '0;
      rdv_r      <= 1'b0;
    end else if (state_r != ST_TEXT) begin
      rd_cnt_r   <= '0;
      emit_cnt_r <= '0;
      rdv_r      <= 1'b0;
    end else begin
      if (glyph_re) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (can_emit) begin
        emit_cnt_r <= emit_cnt_r + 1'b1;
      end
      if (glyph_re) begin
        rdv_r <= 1'b1;
      end else if (can_emit) begin
        rdv_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state and output register load
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    load_out     = 1'b0;
    out_last_nxt = 1'b0;
    out_x_nxt    = sx_r;
    out_y_nxt    = sy_r + COORD_W'(emit_cnt_r);
    out_cnt_nxt  = PIXEL_COUNT_TEXT;
    for (int k = 0; k < 6; k++) begin
      // spacing line is all background
      pix_nxt[k] = (need_data && glyph_rdata[k]) ? fg_rgb : bg_rgb;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = is_text_r ? ST_TEXT : ST_RGB;
        end
      end
      ST_TEXT: begin
        if (can_emit) begin
          load_out     = 1'b1;
          out_last_nxt = (emit_cnt_r == LAST_ROW);
          if (emit_cnt_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RGB: begin
        out_x_nxt   = COORD_W'(div_res.rem);
        out_y_nxt   = COORD_W'(div_res.quot);
        out_cnt_nxt = PIXEL_COUNT_RGB;
        pix_nxt[0]  = expand_rgb332(code_r);
        for (int k = 1; k < 6; k++) begin
          pix_nxt[k] = '0;
        end
        if (out_free) begin
          load_out     = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register, holds a transaction until out_ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r    <= out_x_nxt;
      out_y_r    <= out_y_nxt;
      out_cnt_r  <= out_cnt_nxt;
      out_last_r <= out_last_nxt;
      for (int k = 0; k < 6; k++) begin
        pix_r[k] <= pix_nxt[k];
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_screen_x    = out_x_r;
  assign out_screen_y    = out_y_r;
  assign out_pixel_0     = pix_r[0];
  assign out_pixel_1     = pix_r[1];
  assign out_pixel_2     = pix_r[2];
  assign out_pixel_3     = pix_r[3];
  assign out_pixel_4     = pix_r[4];
  assign out_pixel_5     = pix_r[5];
  assign out_pixel_count = out_cnt_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `TCPR_ASSERT_IMP(a_rdv_row, clk, rst_n, rdv_r, rd_cnt_r == emit_cnt_r + 1'b1, "glyph data not for the next line")
  `TCPR_ASSERT_NXT(a_last_idle, clk, rst_n, load_out && out_last_nxt, (state_r == ST_IDLE) && out_valid_r && out_last_r, "final line did not end the transaction")
  `TCPR_ASSERT_IMP(a_write_idle, clk, rst_n, glyph_we || pal_wr.en, state_r == ST_IDLE, "store written while busy")
  `TCPR_ASSERT_IMP(a_div_wait, clk, rst_n, div_res.done, state_r == ST_DIV, "divider finished outside its wait state")

endmodule
